FILE: rtl/core/bre_pkg.sv
// Package for the bitmap range engine: field widths, request codes and
// word helpers (population count, lowest set bit). No dependencies.
`default_nettype none

package bre_pkg;

	localparam int unsigned DEF_MAX_BITS = 4096;
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned OFF_W        = 5;
	localparam int unsigned OP_W         = 3;
	localparam int unsigned IDX_W        = 12;
	localparam int unsigned CNT_W        = 13;
	localparam int unsigned WCNT_W       = 9;
	localparam int unsigned SIZE_CAP     = 8191;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [OP_W-1:0] {
		OP_TEST       = 3'd0,
		OP_SET_RANGE  = 3'd1,
		OP_CLR_RANGE  = 3'd2,
		OP_FIND       = 3'd3,
		OP_COUNT      = 3'd4,
		OP_SET_ALL    = 3'd5,
		OP_CLR_ALL    = 3'd6,
		OP_INV_ALL    = 3'd7
	} op_t;

	function automatic logic [5:0] pop32(input word_t x);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++)
			l1[i] = 2'(x[2*i]) + 2'(x[2*i+1]);
		for (int i = 0; i < 8; i++)
			l2[i] = 3'(l1[2*i]) + 3'(l1[2*i+1]);
		for (int i = 0; i < 4; i++)
			l3[i] = 4'(l2[2*i]) + 4'(l2[2*i+1]);
		for (int i = 0; i < 2; i++)
			l4[i] = 5'(l3[2*i]) + 5'(l3[2*i+1]);
		return 6'(l4[0]) + 6'(l4[1]);
	endfunction

	function automatic logic [OFF_W-1:0] lsb_index(input word_t x);
		word_t            oh;
		logic [OFF_W-1:0] idx;
		oh  = x & (~x + word_t'(1));
		idx = '0;
		for (int i = 0; i < WORD_W; i++)
			if (oh[i])
				idx = idx | OFF_W'(i);
		return idx;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bitmap_range_engine.sv
// Bitmap range engine: test, set/clear range, find first, count, whole-map ops.
// A request with no word walk has its result registered from the decode; a
// walk request reads one map word per cycle through the registered read stage
// and registers its result after its last word or a find hit. No new request
// is taken until the last one is done. Reset: async, active low; a clearing
// pass then zeroes the map. Depends on bre_pkg.
`default_nettype none

module bitmap_range_engine
	import bre_pkg::*;
#(
	parameter int unsigned MAX_BITS = DEF_MAX_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write_en,
	input  wire logic [CNT_W-1:0] cfg_write_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [OP_W-1:0]  operation,
	input  wire logic [IDX_W-1:0] start_index,
	input  wire logic [CNT_W-1:0] bit_count,
	input  wire logic [IDX_W-1:0] stop_index,
	input  wire logic             wanted_value,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  bit_value,
	output logic [CNT_W-1:0]      found_index,
	output logic [CNT_W-1:0]      set_count,
	output logic                  range_error
);

	localparam int unsigned MAP_WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
	localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned CAP       = (MAX_BITS > SIZE_CAP) ? SIZE_CAP : MAX_BITS;
	localparam logic [CNT_W-1:0] CAP_V     = CNT_W'(CAP);
	localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_WAIT  = 4'b1000
	} state_t;

	word_t mem [MAP_WORDS];

	state_t           state_q;
	logic [AW-1:0]    clr_addr_q;
	logic [CNT_W-1:0] active_bits_q;

	op_t              op_q;
	logic [IDX_W-1:0] stop_q;
	logic             want_q;
	logic [OFF_W-1:0] lo_q;
	logic [OFF_W-1:0] hi_q;
	logic [CNT_W-1:0] cnt_q;

	logic             issuing_q;
	logic             first_q;
	logic [AW-1:0]    rd_addr_q;
	logic [AW-1:0]    last_addr_q;

	logic             valid_s1;
	logic             first_s1;
	logic             last_s1;
	logic [AW-1:0]    addr_s1;
	word_t            rd_data_s1;

	logic             out_valid_q;
	logic             bit_q;
	logic [CNT_W-1:0] found_q;
	logic [CNT_W-1:0] count_q;
	logic             err_q;

	logic             pend_bit_q;
	logic [CNT_W-1:0] pend_found_q;
	logic [CNT_W-1:0] pend_count_q;
	logic             pend_err_q;

	// request decode
	logic             accept;
	logic [CNT_W-1:0] size;
	logic [WCNT_W-1:0] words;
	logic [CNT_W:0]   end_w;
	logic [CNT_W:0]   last_bit;
	logic             walk;
	logic [WCNT_W-1:0] fw;
	logic [WCNT_W-1:0] lw;
	logic [OFF_W-1:0] lo;
	logic [OFF_W-1:0] hi;
	logic             imm_err;
	logic [CNT_W-1:0] imm_found;

	always_comb begin
		size     = (active_bits_q > CAP_V) ? CAP_V : active_bits_q;
		words    = WCNT_W'(({1'b0, size} + (CNT_W+1)'(WORD_W - 1)) >> OFF_W);
		end_w    = (CNT_W+1)'(start_index) + (CNT_W+1)'(bit_count);
		last_bit = end_w - (CNT_W+1)'(1);
		walk      = 1'b0;
		fw        = '0;
		lw        = '0;
		lo        = '0;
		hi        = '1;
		imm_err   = 1'b0;
		imm_found = '0;
		case (op_t'(operation))
			OP_TEST: begin
				lo = start_index[OFF_W-1:0];
				fw = WCNT_W'(start_index >> OFF_W);
				lw = fw;
				if (CNT_W'(start_index) >= size)
					imm_err = 1'b1;
				else
					walk = 1'b1;
			end
			OP_SET_RANGE, OP_CLR_RANGE: begin
				lo = start_index[OFF_W-1:0];
				hi = last_bit[OFF_W-1:0];
				fw = WCNT_W'(start_index >> OFF_W);
				lw = WCNT_W'(last_bit >> OFF_W);
				if (CNT_W'(start_index) >= size || end_w > (CNT_W+1)'(size))
					imm_err = 1'b1;
				else if (bit_count != '0)
					walk = 1'b1;
			end
			OP_FIND: begin
				lo = start_index[OFF_W-1:0];
				hi = stop_index[OFF_W-1:0];
				fw = WCNT_W'(start_index >> OFF_W);
				lw = WCNT_W'(stop_index >> OFF_W);
				if (start_index > stop_index)
					imm_found = CNT_W'(start_index);
				else if (CNT_W'(stop_index) >= size)
					imm_err = 1'b1;
				else
					walk = 1'b1;
			end
			OP_COUNT: begin
				lw = words - WCNT_W'(1);
				if (size[OFF_W-1:0] != '0)
					hi = size[OFF_W-1:0] - OFF_W'(1);
				walk = (words != '0);
			end
			default: begin
				lw   = words - WCNT_W'(1);
				walk = (words != '0);
			end
		endcase
	end

	// word stage
	word_t            mask_s1;
	word_t            hit_vec;
	word_t            wr_data;
	logic [AW-1:0]    wr_addr;
	logic             wr_en;
	logic             hit;
	logic             finish;
	logic             res_go;
	logic             res_bit;
	logic [CNT_W-1:0] res_found;
	logic [CNT_W-1:0] res_count;
	logic             res_err;
	logic [CNT_W-1:0] sum_count;
	logic             slot_free;

	always_comb begin
		mask_s1 = '1;
		if (first_s1)
			mask_s1 = mask_s1 & (word_t'('1) << lo_q);
		if (last_s1)
			mask_s1 = mask_s1 & (word_t'('1) >> (~hi_q));
		hit_vec   = (want_q ? rd_data_s1 : ~rd_data_s1) & mask_s1;
		hit       = (op_q == OP_FIND) && (hit_vec != '0);
		finish    = (state_q == ST_WALK) && valid_s1 && (last_s1 || hit);
		sum_count = cnt_q + CNT_W'(pop32(rd_data_s1 & mask_s1));

		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = rd_data_s1;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (state_q == ST_WALK && valid_s1) begin
			case (op_q)
				OP_SET_RANGE: begin
					wr_en   = 1'b1;
					wr_data = rd_data_s1 | mask_s1;
				end
				OP_CLR_RANGE: begin
					wr_en   = 1'b1;
					wr_data = rd_data_s1 & ~mask_s1;
				end
				OP_SET_ALL: begin
					wr_en   = 1'b1;
					wr_data = '1;
				end
				OP_CLR_ALL: begin
					wr_en   = 1'b1;
					wr_data = '0;
				end
				OP_INV_ALL: begin
					wr_en   = 1'b1;
					wr_data = ~rd_data_s1;
				end
				default: wr_en = 1'b0;
			endcase
		end

		res_go    = 1'b0;
		res_bit   = 1'b0;
		res_found = '0;
		res_count = '0;
		res_err   = 1'b0;
		if (accept && !walk) begin
			res_go    = 1'b1;
			res_err   = imm_err;
			res_found = imm_found;
		end else if (finish) begin
			res_go = 1'b1;
			case (op_q)
				OP_TEST:  res_bit = rd_data_s1[lo_q];
				OP_FIND: begin
					if (hit)
						res_found = CNT_W'((32'(addr_s1) << OFF_W) |
							32'(lsb_index(hit_vec)));
					else
						res_found = CNT_W'(stop_q) + CNT_W'(1);
				end
				OP_COUNT: res_count = sum_count;
				default:  res_count = '0;
			endcase
		end
	end

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && issuing_q)
			rd_data_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bits_q <= CNT_W'(DEF_MAX_BITS);
		end else if (cfg_write_en) begin
			active_bits_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			issuing_q   <= 1'b0;
			first_q     <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_WORD)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && walk) begin
						state_q   <= ST_WALK;
						issuing_q <= 1'b1;
						first_q   <= 1'b1;
						valid_s1  <= 1'b0;
					end
				end
				ST_WALK: begin
					valid_s1 <= issuing_q;
					if (issuing_q) begin
						first_q <= 1'b0;
						if (rd_addr_q == last_addr_q)
							issuing_q <= 1'b0;
					end
					if (finish) begin
						state_q   <= ST_IDLE;
						issuing_q <= 1'b0;
						valid_s1  <= 1'b0;
					end
				end
				ST_WAIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (res_go) begin
				if (slot_free)
					out_valid_q <= 1'b1;
				else
					state_q <= ST_WAIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op_t'(operation);
			stop_q      <= stop_index;
			want_q      <= wanted_value;
			lo_q        <= lo;
			hi_q        <= hi;
			cnt_q       <= '0;
			rd_addr_q   <= AW'(fw);
			last_addr_q <= AW'(lw);
		end else if (state_q == ST_WALK && valid_s1) begin
			cnt_q <= sum_count;
		end
		if (state_q == ST_WALK && issuing_q) begin
			addr_s1   <= rd_addr_q;
			first_s1  <= first_q;
			last_s1   <= (rd_addr_q == last_addr_q);
			rd_addr_q <= rd_addr_q + AW'(1);
		end
		if (res_go) begin
			if (slot_free) begin
				bit_q   <= res_bit;
				found_q <= res_found;
				count_q <= res_count;
				err_q   <= res_err;
			end else begin
				pend_bit_q   <= res_bit;
				pend_found_q <= res_found;
				pend_count_q <= res_count;
				pend_err_q   <= res_err;
			end
		end else if (state_q == ST_WAIT && slot_free) begin
			bit_q   <= pend_bit_q;
			found_q <= pend_found_q;
			count_q <= pend_count_q;
			err_q   <= pend_err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign bit_value   = bit_q;
	assign found_index = found_q;
	assign set_count   = count_q;
	assign range_error = err_q;

endmodule

`default_nettype wire

FILE: rtl/core/bre_checker.sv
// Port-level checks for the bitmap range engine, bound to its top level.
// Depends on bre_pkg.
`default_nettype none

module bre_checker
	import bre_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             cfg_write_en,
	input wire logic [CNT_W-1:0] cfg_write_data,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic [OP_W-1:0]  operation,
	input wire logic [IDX_W-1:0] start_index,
	input wire logic [CNT_W-1:0] bit_count,
	input wire logic [IDX_W-1:0] stop_index,
	input wire logic             wanted_value,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic             bit_value,
	input wire logic [CNT_W-1:0] found_index,
	input wire logic [CNT_W-1:0] set_count,
	input wire logic             range_error
);

	logic [1:0] open_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> !bit_value && found_index == '0 && set_count == '0)
		else $error("error result carries nonzero fields");

	a_bit_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bit_value |-> found_index == '0 && set_count == '0)
		else $error("test result carries other fields");

	a_result_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != 2'd0 && open_q != 2'd3)
		else $error("result without an open request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
			$stable({bit_value, found_index, set_count, range_error}))
		else $error("stalled result changed");

	logic unused_ports;
	assign unused_ports = cfg_write_en ^ (^cfg_write_data) ^ (^operation) ^
		(^start_index) ^ (^bit_count) ^ (^stop_index) ^ wanted_value;

endmodule

bind bitmap_range_engine bre_checker u_bre_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for bitmap_range_engine: directed and random requests
// are checked against a shadow bitmap kept in the testbench.
// Depends on bre_pkg and the bitmap_range_engine RTL.
`timescale 1ns / 1ps

module testbench;
	import bre_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned WALK_CYCLES  = (DEF_MAX_BITS + 31) / 32 + 12;

	typedef struct packed {
		logic             bit_value;
		logic [CNT_W-1:0] found_index;
		logic [CNT_W-1:0] set_count;
		logic             range_error;
	} bre_result_t;

	logic             clk            = 1'b0;
	logic             arst_n         = 1'b0;
	logic             cfg_write_en   = 1'b0;
	logic [CNT_W-1:0] cfg_write_data = '0;
	logic             in_valid       = 1'b0;
	logic             in_stall;
	logic [OP_W-1:0]  operation      = '0;
	logic [IDX_W-1:0] start_index    = '0;
	logic [CNT_W-1:0] bit_count      = '0;
	logic [IDX_W-1:0] stop_index     = '0;
	logic             wanted_value   = 1'b0;
	logic             out_valid;
	logic             out_stall      = 1'b0;
	logic             bit_value;
	logic [CNT_W-1:0] found_index;
	logic [CNT_W-1:0] set_count;
	logic             range_error;

	logic [DEF_MAX_BITS-1:0] shadow_map  = '0;
	logic [CNT_W-1:0]        active_bits = CNT_W'(DEF_MAX_BITS);
	bre_result_t             pending_results[$];
	bre_result_t             oldest;
	bit                      no_gaps     = 1'b0;
	int unsigned             cycle_count = 0;
	int unsigned             requests_sent = 0;
	int unsigned             results_checked = 0;
	int unsigned             size_writes = 0;
	int unsigned             mismatches = 0;

	bitmap_range_engine DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.start_index   (start_index),
		.bit_count     (bit_count),
		.stop_index    (stop_index),
		.wanted_value  (wanted_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.bit_value     (bit_value),
		.found_index   (found_index),
		.set_count     (set_count),
		.range_error   (range_error)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("bitmap_range_engine: mismatch");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= !no_gaps && ($urandom_range(99) < 14);
	end

	function automatic int unsigned map_size();
		return (active_bits > DEF_MAX_BITS) ? DEF_MAX_BITS : int'(active_bits);
	endfunction

	function automatic bre_result_t apply_request(input op_t op, input logic [IDX_W-1:0] first,
			input logic [CNT_W-1:0] len, input logic [IDX_W-1:0] last, input logic want);
		bre_result_t r;
		int unsigned size;
		int unsigned i;
		r = '0;
		size = map_size();
		case (op)
			OP_TEST: begin
				if (first >= size)
					r.range_error = 1'b1;
				else
					r.bit_value = shadow_map[first];
			end
			OP_SET_RANGE, OP_CLR_RANGE: begin
				if (first >= size || int'(first) + int'(len) > size)
					r.range_error = 1'b1;
				else
					for (i = first; i < int'(first) + int'(len); i++)
						shadow_map[i] = (op == OP_SET_RANGE);
			end
			OP_FIND: begin
				if (first > last) begin
					r.found_index = CNT_W'(first);
				end else if (last >= size) begin
					r.range_error = 1'b1;
				end else begin
					i = first;
					while (i <= last && shadow_map[i] != want)
						i++;
					r.found_index = CNT_W'(i);
				end
			end
			OP_COUNT: begin
				for (i = 0; i < size; i++)
					r.set_count += CNT_W'(shadow_map[i]);
			end
			default: begin
				for (i = 0; i < ((size + 31) / 32) * 32; i++)
					shadow_map[i] = (op == OP_SET_ALL) ? 1'b1 :
						(op == OP_CLR_ALL) ? 1'b0 : !shadow_map[i];
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input bre_result_t want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0d: %s: expected bit %0d found %0d count %0d err %0d, got bit %0d found %0d count %0d err %0d",
				cycle_count, what, want.bit_value, want.found_index, want.set_count,
				want.range_error, bit_value, found_index, set_count, range_error);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request waiting", '0);
			end else begin
				oldest = pending_results.pop_front();
				if (bit_value !== oldest.bit_value || found_index !== oldest.found_index ||
						set_count !== oldest.set_count || range_error !== oldest.range_error)
					report_mismatch("field mismatch", oldest);
			end
		end
	end

	task automatic send_request(input op_t op, input logic [IDX_W-1:0] first,
			input logic [CNT_W-1:0] len, input logic [IDX_W-1:0] last, input logic want);
		while (!no_gaps && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		start_index  <= first;
		bit_count    <= len;
		stop_index   <= last;
		wanted_value <= want;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(apply_request(op, first, len, last, want));
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_active_bits(input logic [CNT_W-1:0] value);
		wait_results_drained();
		repeat (4) @(negedge clk);
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		active_bits = value;
		size_writes++;
	endtask

	task automatic send_random_request();
		op_t op;
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] last;
		logic [CNT_W-1:0] len;
		logic want;
		int unsigned size;
		int unsigned pick;
		int unsigned room;
		size = map_size();
		pick = $urandom_range(99);
		op = (pick < 22) ? OP_TEST : (pick < 40) ? OP_SET_RANGE : (pick < 58) ? OP_CLR_RANGE :
			(pick < 82) ? OP_FIND : (pick < 89) ? OP_COUNT : (pick < 93) ? OP_SET_ALL :
			(pick < 96) ? OP_CLR_ALL : OP_INV_ALL;
		first = IDX_W'($urandom);
		last  = IDX_W'($urandom);
		len   = CNT_W'($urandom);
		want  = 1'($urandom);
		if (size != 0 && $urandom_range(99) >= 12) begin
			first = IDX_W'($urandom_range(size - 1));
			room  = size - first;
			len   = CNT_W'(($urandom_range(99) < 70) ? $urandom_range(room < 64 ? room : 64) :
				$urandom_range(room));
			last  = IDX_W'(first + $urandom_range(size - 1 - first));
		end
		send_request(op, first, len, last, want);
	endtask

	task automatic test_after_reset();
		send_request(OP_COUNT, 12'd0, 13'd0, 12'd0, 1'b0);
		send_request(OP_FIND, 12'd0, 13'd0, 12'd4095, 1'b1);
	endtask

	task automatic test_single_bits();
		send_request(OP_SET_RANGE, 12'd0, 13'd1, 12'd0, 1'b0);
		send_request(OP_SET_RANGE, 12'd4095, 13'd1, 12'd0, 1'b0);
		send_request(OP_TEST, 12'd4095, 13'd0, 12'd0, 1'b0);
		send_request(OP_TEST, 12'd4094, 13'd0, 12'd0, 1'b0);
		send_request(OP_SET_RANGE, 12'd100, 13'd0, 12'd0, 1'b0);
		send_request(OP_COUNT, 12'd0, 13'd0, 12'd0, 1'b0);
	endtask

	task automatic test_range_limits();
		send_request(OP_SET_RANGE, 12'd4095, 13'd2, 12'd0, 1'b0);
		send_request(OP_CLR_RANGE, 12'd0, 13'd4096, 12'd0, 1'b0);
		send_request(OP_SET_RANGE, 12'd0, 13'd8191, 12'hfff, 1'b1);
		send_request(OP_TEST, 12'd4095, 13'd0, 12'd0, 1'b0);
	endtask

	task automatic test_find_first();
		send_request(OP_SET_RANGE, 12'd1000, 13'd10, 12'd0, 1'b0);
		send_request(OP_FIND, 12'd0, 13'd0, 12'd4095, 1'b1);
		send_request(OP_FIND, 12'd1000, 13'd0, 12'd4095, 1'b0);
		send_request(OP_FIND, 12'd4095, 13'd0, 12'd7, 1'b1);
	endtask

	task automatic test_whole_map();
		send_request(OP_SET_ALL, 12'd0, 13'd0, 12'd0, 1'b0);
		send_request(OP_COUNT, 12'd0, 13'd0, 12'd0, 1'b0);
		send_request(OP_INV_ALL, 12'd0, 13'd0, 12'd0, 1'b0);
		send_request(OP_FIND, 12'd0, 13'd0, 12'd4095, 1'b1);
	endtask

	task automatic test_size_extremes();
		write_active_bits(13'd0);
		send_request(OP_TEST, 12'd0, 13'd0, 12'd0, 1'b0);
		send_request(OP_FIND, 12'd0, 13'd0, 12'd0, 1'b0);
		send_request(OP_COUNT, 12'd0, 13'd0, 12'd0, 1'b0);
		write_active_bits(13'd8191);
		send_request(OP_COUNT, 12'd0, 13'd0, 12'd0, 1'b0);
		write_active_bits(13'd1);
		send_request(OP_SET_ALL, 12'd0, 13'd0, 12'd0, 1'b0);
		send_request(OP_TEST, 12'd1, 13'd0, 12'd0, 1'b0);
		send_request(OP_COUNT, 12'd0, 13'd0, 12'd0, 1'b0);
		write_active_bits(13'd64);
		send_request(OP_COUNT, 12'd0, 13'd0, 12'd0, 1'b0);
	endtask

	task automatic run_random_phase(input logic [CNT_W-1:0] size_value, input int unsigned items);
		write_active_bits(size_value);
		repeat (items) send_random_request();
	endtask

	task automatic test_random_sizes();
		run_random_phase(13'd4096, 180);
		run_random_phase(13'd1, 120);
		run_random_phase(13'd32, 150);
		run_random_phase(13'd33, 150);
		run_random_phase(CNT_W'($urandom_range(2, 200)), 180);
		run_random_phase(13'd4095, 180);
		run_random_phase(13'd0, 20);
		run_random_phase(13'd8191, 150);
		run_random_phase(CNT_W'($urandom_range(1, 4096)), 150);
	endtask

	task automatic test_back_to_back();
		write_active_bits(CNT_W'($urandom_range(100, 4096)));
		no_gaps = 1'b1;
		repeat (250) send_random_request();
		no_gaps = 1'b0;
	endtask

	task automatic test_drain_pause();
		write_active_bits(CNT_W'($urandom_range(1, 1024)));
		for (int k = 0; k < 200; k++) begin
			if (k % 25 == 0)
				wait_results_drained();
			send_random_request();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_after_reset();
		test_single_bits();
		test_range_limits();
		test_find_first();
		test_whole_map();
		test_size_extremes();
		test_random_sizes();
		test_back_to_back();
		test_drain_pause();
		wait_results_drained();
		repeat (WALK_CYCLES) @(posedge clk);
		$display("ran %0d requests over %0d size settings, checked %0d results",
			requests_sent, size_writes, results_checked);
		$display("all operations, range limits, zero and oversize maps, back-to-back and drained traffic");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("bitmap_range_engine: match");
		else
			$display("bitmap_range_engine: mismatch");
		$finish;
	end

endmodule
